// File: hdl/qesp_pkg.sv
// Package for the quadrature encoder speed/position block: field widths,
// register indexes, reset values and the sequencer state type.
// No dependencies.
`default_nettype none

package qesp_pkg;

    // Parameter defaults
    localparam int NUM_MOTORS_DEF   = 3;
    localparam int COUNTER_BITS_DEF = 16;

    // Fixed field widths
    localparam int IN_MOTORS = 3;            // motors with channel inputs
    localparam int IN_CH_W   = 2 * IN_MOTORS;
    localparam int IN_DATA_W = 8;            // channel levels padded to a byte
    localparam int QSEL_W    = 2;
    localparam int POS_W     = 32;           // raw position
    localparam int WRAP_W    = 16;
    localparam int SC_W      = 24;           // speed constant
    localparam int CFG_W     = 24;
    localparam int POSOUT_W  = 17;
    localparam int SPEED_W   = 16;
    localparam int OUT_DATA_W = 40;          // 35 bits of fields, padded
    localparam int STEP_W    = 5;            // counts the 32 divide steps

    localparam logic [SPEED_W-2:0] SPEED_MAX = '1;

    // Configuration register indexes
    localparam logic CFG_SPEED_NUM     = 1'b0;
    localparam logic CFG_POSITION_WRAP = 1'b1;

    // Register reset values
    localparam logic [SC_W-1:0]   SPEED_NUM_RST     = 24'd8342855;
    localparam logic [WRAP_W-1:0] POSITION_WRAP_RST = 16'd720;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } qesp_state_t;

endpackage

`default_nettype wire

// File: hdl/quadrature_encoder_speed_position.sv
// Top level of the quadrature encoder speed/position block: per-motor
// edge tracking and two bit-serial dividers for position and speed.
// Depends on qesp_pkg.
//
// Usage:
//   s_* channel: one beat per prescaled timer tick. s_tdata carries the
//   channel 0/1 levels of motors A, B, C; s_tuser selects the motor to report.
//   m_* channel: one result beat per input beat, in order. m_tuser flags an
//   invalid motor index, in which case all m_tdata fields are zero.
//   cfg_we/cfg_index/cfg_data: write the speed numerator (0) or position_wrap (1).
// Sequencing:
//   The beat updates every motor in the accept cycle. Position modulo wrap
//   and speed numerator over period are then worked out by two restoring
//   dividers, one quotient bit per cycle, running side by side (the
//   position divider sets the length). In the done state the result is
//   loaded into the output register as soon as that register is free; an
//   invalid query skips the dividers and goes straight to the done state.
//   A new beat is taken only while no query is in the dividers, nor until
//   the last result has been loaded.
// Reset:
//   rst_n clears all motor state, loads the register reset values and
//   empties the output register. While m_tready is low a finished result
//   holds in the output register; the next query may run meanwhile and waits
//   for the register to free up.
`default_nettype none

module quadrature_encoder_speed_position
    import qesp_pkg::*;
#(
    parameter int NUM_MOTORS   = NUM_MOTORS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input beats
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // [0] A ch0, [1] A ch1, [2] B ch0, [3] B ch1, [4] C ch0, [5] C ch1
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] query_motor
    input  wire logic [QSEL_W-1:0]     s_tuser,
    // result beats
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // [16:0] position, [32:17] speed, [33] direction, [34] stalled
    output      logic [OUT_DATA_W-1:0] m_tdata,
    // [0] query_error
    output      logic                  m_tuser,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    localparam int LVL_W = 2 * NUM_MOTORS;
    localparam int CB    = COUNTER_BITS;

    // ---------------- configuration registers ----------------
    logic [SC_W-1:0]   speed_num_reg;
    logic [WRAP_W-1:0] position_wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_num_reg     <= SPEED_NUM_RST;
            position_wrap_reg <= POSITION_WRAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SPEED_NUM:     speed_num_reg     <= cfg_data[SC_W-1:0];
                CFG_POSITION_WRAP: position_wrap_reg <= cfg_data[WRAP_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------- sequencer control ----------------
    qesp_state_t      state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic             accept, load_out, last_step;

    assign accept    = s_tvalid && s_tready;
    assign last_step = (cnt_reg == STEP_W'(POS_W - 1));

    // ---------------- per-motor lanes ----------------
    logic [POS_W-1:0] pos_reg    [NUM_MOTORS];
    logic [CB-1:0]    tick_reg   [NUM_MOTORS];
    logic [CB-1:0]    period_reg [NUM_MOTORS];
    logic             back_reg   [NUM_MOTORS];
    logic             stall_reg  [NUM_MOTORS];
    logic             last0_reg  [NUM_MOTORS];
    logic             last1_reg  [NUM_MOTORS];

    logic [POS_W-1:0] pos_next    [NUM_MOTORS];
    logic [CB-1:0]    tick_next   [NUM_MOTORS];
    logic [CB-1:0]    period_next [NUM_MOTORS];
    logic             back_next   [NUM_MOTORS];
    logic             stall_next  [NUM_MOTORS];

    // channel levels, motors without inputs see both channels low
    logic [LVL_W+IN_CH_W-1:0] lvl_pad;
    assign lvl_pad = {{LVL_W{1'b0}}, s_tdata[IN_CH_W-1:0]};

    // lane update: edge detect, position step, period capture, stall
    always_comb
    begin
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            logic c0, c1, changed, rise;
            logic [CB-1:0] tick_inc;
            c0       = lvl_pad[2*m];
            c1       = lvl_pad[2*m+1];
            changed  = (c0 != last0_reg[m]) || (c1 != last1_reg[m]);
            rise     = !last0_reg[m] && c0;
            tick_inc = tick_reg[m] + CB'(1);

            pos_next[m] = pos_reg[m];
            if (changed && !stall_reg[m])
                pos_next[m] = back_reg[m] ? pos_reg[m] - POS_W'(1)
                                          : pos_reg[m] + POS_W'(1);

            period_next[m] = period_reg[m];
            stall_next[m]  = stall_reg[m];
            back_next[m]   = back_reg[m];
            if (rise)
            begin
                period_next[m] = tick_reg[m];
                tick_next[m]   = '0;
                stall_next[m]  = 1'b0;
                back_next[m]   = !c1;
            end
            else
            begin
                tick_next[m] = tick_inc;
                if (tick_inc == '0)
                begin
                    stall_next[m]  = 1'b1;
                    period_next[m] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < NUM_MOTORS; m++)
            begin
                pos_reg[m]    <= '0;
                tick_reg[m]   <= '0;
                period_reg[m] <= '0;
                back_reg[m]   <= 1'b0;
                stall_reg[m]  <= 1'b0;
                last0_reg[m]  <= 1'b0;
                last1_reg[m]  <= 1'b0;
            end
        end
        else if (accept)
        begin
            for (int m = 0; m < NUM_MOTORS; m++)
            begin
                pos_reg[m]    <= pos_next[m];
                tick_reg[m]   <= tick_next[m];
                period_reg[m] <= period_next[m];
                back_reg[m]   <= back_next[m];
                stall_reg[m]  <= stall_next[m];
                last0_reg[m]  <= lvl_pad[2*m];
                last1_reg[m]  <= lvl_pad[2*m+1];
            end
        end
    end

    // ---------------- query select from updated state ----------------
    logic             q_err;
    logic [POS_W-1:0] q_pos;
    logic [CB-1:0]    q_period;
    logic             q_back, q_stall;

    always_comb
    begin
        q_err    = (32'(s_tuser) >= NUM_MOTORS);
        q_pos    = '0;
        q_period = '0;
        q_back   = 1'b0;
        q_stall  = 1'b0;
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            if (32'(s_tuser) == m)
            begin
                q_pos    = pos_next[m];
                q_period = period_next[m];
                q_back   = back_next[m];
                q_stall  = stall_next[m];
            end
        end
    end

    // ---------------- bit-serial dividers ----------------
    logic [POS_W-1:0]  pdiv_reg;     // |position| shifting out
    logic [WRAP_W:0]   prem_reg;     // partial remainder
    logic              pneg_reg;
    logic [SC_W-1:0]   sdiv_reg;     // dividend out, quotient in
    logic [CB-1:0]     srem_reg;
    logic [CB-1:0]     per_reg;
    logic              dir_reg, stl_reg, err_reg;

    logic [WRAP_W:0]   wrap_div;
    logic [WRAP_W+1:0] ptrial;
    logic              pge;
    logic [CB:0]       strial;
    logic              sge;

    assign wrap_div = (position_wrap_reg == '0) ? {1'b1, {WRAP_W{1'b0}}}
                                                : {1'b0, position_wrap_reg};
    assign ptrial   = {prem_reg, pdiv_reg[POS_W-1]};
    assign pge      = (ptrial >= {1'b0, wrap_div});
    assign strial   = {srem_reg, sdiv_reg[SC_W-1]};
    assign sge      = (strial >= {1'b0, per_reg});

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pdiv_reg <= q_pos[POS_W-1] ? (~q_pos + POS_W'(1)) : q_pos;
            pneg_reg <= q_pos[POS_W-1];
            prem_reg <= '0;
            sdiv_reg <= speed_num_reg;
            srem_reg <= '0;
            per_reg  <= q_period;
            dir_reg  <= q_back;
            stl_reg  <= q_stall;
            err_reg  <= q_err;
        end
        else if (state_reg == ST_DIV)
        begin
            // position: one remainder bit per cycle for all 32 bits
            pdiv_reg <= {pdiv_reg[POS_W-2:0], 1'b0};
            prem_reg <= pge ? (WRAP_W+1)'(ptrial - {1'b0, wrap_div})
                            : ptrial[WRAP_W:0];
            // speed: one quotient bit per cycle over the first 24 steps
            if (cnt_reg < STEP_W'(SC_W))
            begin
                sdiv_reg <= {sdiv_reg[SC_W-2:0], sge};
                srem_reg <= sge ? CB'(strial - {1'b0, per_reg}) : strial[CB-1:0];
            end
        end
    end

    // ---------------- result formatting ----------------
    logic [SPEED_W-2:0]  speed_mag;
    logic [SPEED_W-1:0]  speed_val;
    logic [POSOUT_W-1:0] pos_val;
    logic [OUT_DATA_W-1:0] res_data;

    always_comb
    begin
        speed_mag = (|sdiv_reg[SC_W-1:SPEED_W-1]) ? SPEED_MAX
                                                  : sdiv_reg[SPEED_W-2:0];
        if (stl_reg || (per_reg == '0))
            speed_val = '0;
        else if (dir_reg)
            speed_val = ~{1'b0, speed_mag} + SPEED_W'(1);
        else
            speed_val = {1'b0, speed_mag};
        pos_val = pneg_reg ? (~prem_reg + POSOUT_W'(1)) : prem_reg;
        if (err_reg)
            res_data = '0;
        else
            res_data = {5'b0, stl_reg, dir_reg, speed_val, pos_val};
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_tdata <= res_data;
            m_tuser <= err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                cnt_reg <= '0;
            else if (state_reg == ST_DIV)
                cnt_reg <= cnt_reg + STEP_W'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = q_err ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (last_step)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_DIV:  ;
            ST_DONE: load_out = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    // ---------------- assertions ----------------
    a_err_skips_div: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && q_err) |=> (state_reg == ST_DONE && err_reg))
        else $error("invalid query did not bypass the dividers");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !q_err) |=> (state_reg == ST_DIV && cnt_reg == '0))
        else $error("valid query did not start the dividers at step zero");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("error beat carries nonzero fields");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !load_out)
        else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/quadrature_encoder_speed_position_tb.sv
// Self-checking testbench for quadrature_encoder_speed_position: drives encoder
// tick beats, predicts every result beat and compares it field by field.
// Depends on qesp_pkg and the quadrature_encoder_speed_position RTL.
`default_nettype none

module quadrature_encoder_speed_position_tb
    import qesp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int MOTORS        = NUM_MOTORS_DEF;
    localparam int CHUNK_TICKS   = 113;
    localparam int LONG_TICKS    = 160;           // held-still run
    localparam int SETTLE_CYCLES = 80;            // longer than one divide
    // generous limit; margin covers slow receivers on every beat
    localparam int CYCLE_LIMIT   = 5000000;

    // query selector codes
    localparam logic [QSEL_W-1:0] MOTOR_A  = 2'd0;
    localparam logic [QSEL_W-1:0] MOTOR_B  = 2'd1;
    localparam logic [QSEL_W-1:0] MOTOR_C  = 2'd2;
    localparam logic [QSEL_W-1:0] NO_MOTOR = 2'd3;

    // result field offsets in m_tdata
    localparam int SPD_LSB = POSOUT_W;
    localparam int DIR_BIT = POSOUT_W + SPEED_W;
    localparam int STL_BIT = DIR_BIT + 1;

    typedef struct packed {
        logic [IN_CH_W-1:0] ch;
        logic [QSEL_W-1:0]  q;
    } tick_t;

    typedef struct packed {
        logic                       err;
        logic signed [POSOUT_W-1:0] pos;
        logic signed [SPEED_W-1:0]  spd;
        logic                       dir;
        logic                       stl;
    } report_t;

    // DUT connections, all inputs known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [QSEL_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = CFG_SPEED_NUM;
    logic [CFG_W-1:0]      cfg_data  = '0;

    // predicted encoder state and register copies
    logic [POS_W-1:0]  enc_pos    [MOTORS];
    logic [15:0]       enc_ticks  [MOTORS];
    logic [15:0]       enc_period [MOTORS];
    logic              enc_bwd    [MOTORS];
    logic              enc_stall  [MOTORS];
    logic              enc_last0  [MOTORS];
    logic              enc_last1  [MOTORS];
    logic [SC_W-1:0]   speed_k;
    logic [WRAP_W-1:0] wrap_reg;

    tick_t   pending_ticks[$];
    report_t expected_reports[$];
    tick_t   beat_in_flight;
    logic [IN_CH_W-1:0] stim_levels = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int ticks_sent     = 0;
    int reports_seen   = 0;
    int stall_reports  = 0;
    int invalid_reports = 0;
    int reg_writes     = 0;
    int cycle_count    = 0;

    quadrature_encoder_speed_position uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Advance every motor by one tick, then answer the query from the new state
    function automatic report_t advance_encoders(tick_t t);
        report_t     rpt;
        logic        c0, c1, moved, rose;
        longint      raw_s, modulus, rem;
        int unsigned quo;
        int          sp;
        int          qi;
        rpt = '0;
        for (int m = 0; m < MOTORS; m++)
        begin
            c0 = t.ch[2*m];
            c1 = t.ch[2*m+1];
            moved = (c0 != enc_last0[m]) || (c1 != enc_last1[m]);
            rose = !enc_last0[m] && c0;
            // position moves with the direction and stall flag from before the tick
            if (moved && !enc_stall[m])
                enc_pos[m] = enc_bwd[m] ? enc_pos[m] - 32'd1 : enc_pos[m] + 32'd1;
            if (rose)
            begin
                enc_period[m] = enc_ticks[m];
                enc_ticks[m]  = '0;
                enc_stall[m]  = 1'b0;
                enc_bwd[m]    = ~c1;
            end
            else
            begin
                enc_ticks[m] = enc_ticks[m] + 16'd1;
                if (enc_ticks[m] == '0)
                begin
                    enc_stall[m]  = 1'b1;
                    enc_period[m] = '0;
                end
            end
            enc_last0[m] = c0;
            enc_last1[m] = c1;
        end
        if (t.q >= MOTORS)
        begin
            rpt.err = 1'b1;
            return rpt;
        end
        qi = t.q;
        // remainder truncated toward zero; a zero wrap means 65536
        raw_s   = longint'($signed(enc_pos[qi]));
        modulus = (wrap_reg == '0) ? 64'sd65536 : longint'(wrap_reg);
        rem     = raw_s % modulus;
        rpt.pos = rem[POSOUT_W-1:0];
        if (!enc_stall[qi] && enc_period[qi] != '0)
        begin
            quo = speed_k / enc_period[qi];
            if (quo > 32767)
                quo = 32767;
            sp = enc_bwd[qi] ? -int'(quo) : int'(quo);
            rpt.spd = sp[SPEED_W-1:0];
        end
        rpt.dir = enc_bwd[qi];
        rpt.stl = enc_stall[qi];
        return rpt;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic push_tick(input logic [IN_CH_W-1:0] ch, input logic [QSEL_W-1:0] q);
        tick_t t;
        t.ch = ch;
        t.q  = q;
        pending_ticks.push_back(t);
        stim_levels = ch;
    endtask

    // Sender holds off until every queued tick is taken and every result is back
    task automatic drain();
        while (pending_ticks.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [CFG_W-1:0] val);
        drain();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SPEED_NUM)
            speed_k = val[SC_W-1:0];
        else
            wrap_reg = val[WRAP_W-1:0];
        reg_writes++;
    endtask

    // Driver: feeds tick beats from the pending queue, predicts on accept
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_reports.push_back(advance_encoders(beat_in_flight));
                ticks_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    beat_in_flight = pending_ticks.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W - IN_CH_W){1'b0}}, beat_in_flight.ch};
                    s_tuser  <= beat_in_flight.q;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reports.size() == 0)
            begin
                errors++;
                $display("%0t ns: result beat with nothing expected, tdata=%h tuser=%b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = expected_reports.pop_front();
                reports_seen++;
                if (want.err)
                    invalid_reports++;
                if (want.stl)
                    stall_reports++;
                check_field("query_error", want.err, m_tuser);
                check_field("position", want.pos, $signed(m_tdata[POSOUT_W-1:0]));
                check_field("speed", want.spd, $signed(m_tdata[SPD_LSB +: SPEED_W]));
                check_field("direction", want.dir, m_tdata[DIR_BIT]);
                check_field("stalled", want.stl, m_tdata[STL_BIT]);
                check_field("padding", 0, m_tdata[OUT_DATA_W-1:STL_BIT+1]);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [IN_CH_W-1:0] ch;
        logic [1:0]         g;
        logic [QSEL_W-1:0]  qsel;
        int                 r;
        int                 move_pct [MOTORS];
        bit                 walk_dir [MOTORS];
        int unsigned        speed_k_set [13];
        int unsigned        wrap_set [13];

        for (int m = 0; m < MOTORS; m++)
        begin
            enc_pos[m]    = '0;
            enc_ticks[m]  = '0;
            enc_period[m] = '0;
            enc_bwd[m]    = 1'b0;
            enc_stall[m]  = 1'b0;
            enc_last0[m]  = 1'b0;
            enc_last1[m]  = 1'b0;
            walk_dir[m]   = 1'b0;
        end
        speed_k  = SPEED_NUM_RST;
        wrap_reg = POSITION_WRAP_RST;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset values, first rise after reset, forward and
        // backward motion, both levels changing at once, invalid queries
        push_tick(6'b000000, MOTOR_A);
        push_tick(6'b000011, MOTOR_A);
        push_tick(6'b000010, MOTOR_A);
        push_tick(6'b000011, MOTOR_A);
        push_tick(6'b000111, MOTOR_B);
        push_tick(6'b001111, MOTOR_B);
        push_tick(6'b001011, MOTOR_B);
        push_tick(6'b000011, MOTOR_B);
        push_tick(6'b110011, MOTOR_C);
        push_tick(6'b111111, NO_MOTOR);
        push_tick(6'b000000, NO_MOTOR);
        // wrap of one and a zero speed numerator
        write_register(CFG_POSITION_WRAP, 24'd1);
        write_register(CFG_SPEED_NUM, 24'd0);
        push_tick(6'b000001, MOTOR_A);
        push_tick(6'b000101, MOTOR_B);
        push_tick(6'b010101, MOTOR_C);
        // zero wrap acts as 65536; largest speed numerator
        write_register(CFG_POSITION_WRAP, 24'd0);
        write_register(CFG_SPEED_NUM, 24'hFFFFFF);
        push_tick(6'b011101, MOTOR_B);
        push_tick(6'b011111, MOTOR_A);
        // largest nonzero wrap, smallest nonzero speed numerator
        write_register(CFG_POSITION_WRAP, 24'd65535);
        write_register(CFG_SPEED_NUM, 24'd1);
        push_tick(6'b011011, MOTOR_B);
        push_tick(6'b111011, MOTOR_C);

        speed_k_set = '{SPEED_NUM_RST, 1, 24'hFFFFFF, 1000, 0, 40000, 2000000,
                        250, 0, 8000, 24'hFFFFFF, 0, SPEED_NUM_RST};
        wrap_set    = '{POSITION_WRAP_RST, 1, 65535, 7, 0, 360, 2, 0, 65535,
                        POSITION_WRAP_RST, 13, 0, 4096};

        // Random quadrature walks with occasional glitches, one chunk per
        // register setting and idle mode; the held-still run goes before the last
        for (int k = 0; k < 13; k++)
        begin
            if (k == 12)
            begin
                // A held still, B flips channel 1 only, C steps backwards every
                // tick: A and B see no channel 0 rise while C keeps moving
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                drain();
                ch = stim_levels;
                for (int i = 0; i < LONG_TICKS; i++)
                begin
                    if (i % 7 == 0)
                        ch[3] = ~ch[3];
                    g = {ch[4], ch[4] ^ ch[5]} - 2'd1;
                    ch[4] = g[1];
                    ch[5] = g[1] ^ g[0];
                    qsel = (i % 32 == 31) ? QSEL_W'((i / 32) % 3) : NO_MOTOR;
                    push_tick(ch, qsel);
                end
            end
            case (k % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            write_register(CFG_SPEED_NUM,
                           CFG_W'((speed_k_set[k] == 0) ? $urandom_range(16777215, 1)
                                                        : speed_k_set[k]));
            write_register(CFG_POSITION_WRAP,
                           CFG_W'((wrap_set[k] == 0) ? $urandom_range(65535, 1)
                                                     : wrap_set[k]));
            for (int m = 0; m < MOTORS; m++)
            begin
                case ($urandom_range(3))
                    0: move_pct[m] = 95;
                    1: move_pct[m] = 60;
                    2: move_pct[m] = 25;
                    default: move_pct[m] = 5;
                endcase
            end
            for (int i = 0; i < CHUNK_TICKS; i++)
            begin
                ch = stim_levels;
                for (int m = 0; m < MOTORS; m++)
                begin
                    r = $urandom_range(99);
                    g = {ch[2*m], ch[2*m] ^ ch[2*m+1]};
                    if (r < move_pct[m])
                    begin
                        if ($urandom_range(9) == 0)
                            walk_dir[m] = ~walk_dir[m];
                        g = walk_dir[m] ? g - 2'd1 : g + 2'd1;
                    end
                    else if (r < move_pct[m] + 4)
                        g = 2'($urandom_range(3));
                    ch[2*m]   = g[1];
                    ch[2*m+1] = g[1] ^ g[0];
                end
                qsel = ($urandom_range(9) == 0) ? NO_MOTOR : QSEL_W'($urandom_range(2));
                push_tick(ch, qsel);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d tick beats over %0d register writes; checked %0d results",
                 ticks_sent, reg_writes, reports_seen);
        $display("  including %0d stalled and %0d invalid-motor reports, %0d mismatches",
                 stall_reports, invalid_reports, errors);
        if (errors == 0 && expected_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hdl/qesp_pkg.sv
hdl/quadrature_encoder_speed_position.sv
tb/quadrature_encoder_speed_position_tb.sv
